// ===== rtl/core/bwtw_pkg.sv =====
// shared types, codes and helper functions for the breit-wigner block
`timescale 1ns / 1ps
package bwtw_pkg;

  // register indexes of the configuration port
  localparam logic [1:0] REG_RES_MASS    = 2'd0;
  localparam logic [1:0] REG_RES_WIDTH   = 2'd1;
  localparam logic [1:0] REG_POINT_COUNT = 2'd2;

  // width of the shared multiply/divide unit
  localparam int unsigned UW = 128;
  // interpolated integral, signed, holds +/- 2^40
  localparam int unsigned PSI_W = 42;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_CAPTURE, OP_SCAN_INIT, OP_SCAN,
    OP_PSI_DIRECT, OP_START, OP_LATCH, OP_EMIT
  } op_t;

  typedef enum logic [3:0] {
    STEP_IP_MUL, STEP_IP_DIV, STEP_RATIO, STEP_A, STEP_M0SQ, STEP_MSQ,
    STEP_C, STEP_BB, STEP_CC, STEP_NRE, STEP_DRE, STEP_NIM, STEP_DIM
  } step_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN_INIT, S_SCAN, S_SEG, S_PASS, S_GO, S_WAIT,
    S_CHK_REF, S_CHK_DEN, S_FIN
  } state_t;

  typedef struct packed {
    op_t   op;
    step_t step;
    logic  pass;
    logic  inv;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic seg_flat;
    logic unit_done;
    logic ref_zero;
    logic den_zero;
  } status_t;

  typedef struct packed {
    logic        sat;
    logic [31:0] field;
  } field_t;

  // steps that run the unit as a divider
  function automatic logic step_is_div(step_t s);
    return (s == STEP_IP_DIV) || (s == STEP_RATIO) || (s == STEP_DRE) || (s == STEP_DIM);
  endfunction

  // clip a quotient magnitude into a signed 32-bit field
  function automatic field_t to_field(logic [UW-1:0] q, logic sign);
    field_t      r;
    logic        neg;
    logic [31:0] limit;
    logic [31:0] mag;
    neg   = sign && (q != '0);
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    r.sat = 1'b0;
    mag   = q[31:0];
    if ((q[UW-1:32] != '0) || (q[31:0] > limit)) begin
      mag   = limit;
      r.sat = 1'b1;
    end
    r.field = neg ? (~mag + 32'd1) : mag;
    return r;
  endfunction

endpackage

// ===== rtl/core/bwtw_muldiv.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
`timescale 1ns / 1ps
module bwtw_muldiv import bwtw_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          is_div,
  input  logic [UW-1:0] op_a,
  input  logic [UW-1:0] op_b,
  output logic          done,
  output logic [UW-1:0] result
);

  localparam int unsigned MUL_STEPS = 64;
  localparam int unsigned DIV_STEPS = UW;
  localparam int unsigned CNT_W     = $clog2(UW);

  logic             busy;
  logic             mode_div;
  logic [CNT_W-1:0] count;
  // mul: acc product, work multiplicand, den multiplier
  // div: acc remainder, work dividend/quotient, den divisor
  logic [UW-1:0]    acc;
  logic [UW-1:0]    work;
  logic [UW-1:0]    den;
  logic [UW+1:0]    trial;

  // trial subtract for the restoring divider
  assign trial  = {1'b0, acc, work[UW-1]} - {2'b00, den};
  assign result = mode_div ? work : acc;

  // control of the iteration
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && (count == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // datapath of the iteration
  always_ff @(posedge clk) begin
    if (start) begin
      mode_div <= is_div;
      count    <= is_div ? CNT_W'(DIV_STEPS - 1) : CNT_W'(MUL_STEPS - 1);
      acc      <= '0;
      work     <= op_a;
      den      <= op_b;
    end else if (busy) begin
      count <= count - 1'b1;
      if (mode_div) begin
        if (!trial[UW+1]) begin
          acc <= trial[UW-1:0];
        end else begin
          acc <= {acc[UW-2:0], work[UW-1]};
        end
        work <= {work[UW-2:0], ~trial[UW+1]};
      end else begin
        if (den[0]) begin
          acc <= acc + work;
        end
        work <= {work[UW-2:0], 1'b0};
        den  <= {1'b0, den[UW-1:1]};
      end
    end
  end

endmodule

// ===== rtl/core/bwtw_datapath.sv =====
// table memory, configuration, scan, arithmetic registers and result register
`timescale 1ns / 1ps
module bwtw_datapath import bwtw_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic [5:0]         point_index,
  input  logic [31:0]        point_mass,
  input  logic [31:0]        point_integral,
  input  logic [31:0]        mass,
  output logic signed [31:0] amp_real,
  output logic signed [31:0] amp_imag,
  output logic               saturated,
  output logic               invalid
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = (AW + 1 > 7) ? AW + 1 : 7;

  // configuration registers
  logic [31:0] res_mass;
  logic [31:0] res_width;
  logic [6:0]  point_count;

  // table memory, mass in the upper half
  logic [63:0] mem [TABLE_DEPTH];
  logic [63:0] rd_data;
  logic        mem_we;

  // scan state
  logic [AW:0]   scan_pos;
  logic [AW-1:0] rd_pos;
  logic          rd_v;
  logic          scan_done;
  logic [31:0]   prev_mass;
  logic [31:0]   prev_int;
  logic [31:0]   ml, mc, il, ic;
  logic [CW-1:0] pc_ext;
  logic [CW-1:0] n_pts;
  logic [AW-1:0] last_pos;
  logic [31:0]   x;
  logic [31:0]   cur_mass;
  logic [31:0]   cur_int;

  // arithmetic registers
  logic [31:0]       mass_reg;
  logic              sat;
  logic [PSI_W-1:0]  psi_m;
  logic [PSI_W-1:0]  psi_m0;
  logic [30:0]       r_reg;
  logic [63:0]       a_reg;
  logic [63:0]       sq_reg;
  logic              bneg;
  logic [39:0]       bmag;
  logic [54:0]       cmag;
  logic [79:0]       bb_reg;
  logic [110:0]      den_reg;
  logic [31:0]       re_reg;
  logic [31:0]       im_reg;

  // unit connections
  logic [UW-1:0] op_a;
  logic [UW-1:0] op_b;
  logic [UW-1:0] res;
  logic          unit_done;

  // interpolation terms
  logic [31:0]        adi, adx, dm;
  logic               sub;
  logic [63:0]        q;
  logic               q_over;
  logic [41:0]        qc;
  logic signed [43:0] base;
  logic signed [43:0] v;
  logic signed [43:0] v_clip;
  logic               v_sat;
  logic [PSI_W-1:0]   psi_m_neg;
  logic [PSI_W-1:0]   psi_m0_neg;
  logic [40:0]        apsi;
  logic [40:0]        apsi0;
  logic               rneg;
  logic [63:0]        msq;
  logic [63:0]        bdiff;
  field_t             fld_re;
  field_t             fld_im;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      res_mass    <= '0;
      res_width   <= '0;
      point_count <= 7'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_RES_MASS:    res_mass    <= cfg_data;
        REG_RES_WIDTH:   res_width   <= cfg_data;
        REG_POINT_COUNT: point_count <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // table memory
  assign mem_we = (cmd.op == OP_LOAD) && (32'(point_index) < 32'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[AW'(point_index)] <= {point_mass, point_integral};
    end
    rd_data <= mem[scan_pos[AW-1:0]];
  end

  // number of points in use, clamped to at least two and at most the table depth
  always_comb begin
    pc_ext = CW'(point_count);
    if (pc_ext < CW'(2)) begin
      n_pts = CW'(2);
    end else if (pc_ext > CW'(TABLE_DEPTH)) begin
      n_pts = CW'(TABLE_DEPTH);
    end else begin
      n_pts = pc_ext;
    end
  end

  assign last_pos = AW'(n_pts - CW'(1));
  assign x        = cmd.pass ? res_mass : mass_reg;
  assign cur_mass = rd_data[63:32];
  assign cur_int  = rd_data[31:0];

  // linear scan for the bracketing segment
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_done <= 1'b0;
      rd_v      <= 1'b0;
    end else if (cmd.op == OP_SCAN_INIT) begin
      scan_done <= 1'b0;
      rd_v      <= 1'b0;
    end else if (cmd.op == OP_SCAN) begin
      rd_v <= 1'b1;
      if (rd_v && !scan_done && (rd_pos != '0) &&
          (((prev_mass <= x) && (x < cur_mass)) || (rd_pos == last_pos))) begin
        scan_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_SCAN_INIT) begin
      scan_pos <= '0;
    end else if (cmd.op == OP_SCAN) begin
      scan_pos <= scan_pos + 1'b1;
      rd_pos   <= scan_pos[AW-1:0];
      if (rd_v && !scan_done) begin
        prev_mass <= cur_mass;
        prev_int  <= cur_int;
        if ((rd_pos != '0) &&
            (((prev_mass <= x) && (x < cur_mass)) || (rd_pos == last_pos))) begin
          ml <= prev_mass;
          il <= prev_int;
          mc <= cur_mass;
          ic <= cur_int;
        end
      end
    end
  end

  // interpolation terms of the chosen segment
  assign adi = (ic < il) ? (il - ic) : (ic - il);
  assign adx = (x < ml) ? (ml - x) : (x - ml);
  assign dm  = mc - ml;
  assign sub = (ic < il) != (x < ml);

  always_comb begin
    q      = res[63:0];
    q_over = q > 64'h0000_0200_0000_0000;
    qc     = q_over ? 42'h200_0000_0000 : q[41:0];
    base   = $signed({12'd0, il});
    v      = sub ? (base - $signed({2'b00, qc})) : (base + $signed({2'b00, qc}));
    v_sat  = 1'b0;
    v_clip = v;
    if (v > 44'sh100_0000_0000) begin
      v_clip = 44'sh100_0000_0000;
      v_sat  = 1'b1;
    end else if (v < -44'sh100_0000_0000) begin
      v_clip = -44'sh100_0000_0000;
      v_sat  = 1'b1;
    end
  end

  // magnitudes and signs of the two integrals
  assign psi_m_neg  = -psi_m;
  assign psi_m0_neg = -psi_m0;
  assign apsi       = psi_m[PSI_W-1] ? psi_m_neg[40:0] : psi_m[40:0];
  assign apsi0      = psi_m0[PSI_W-1] ? psi_m0_neg[40:0] : psi_m0[40:0];
  assign rneg       = psi_m[PSI_W-1] ^ psi_m0[PSI_W-1];

  assign msq    = res[63:0];
  assign bdiff  = (sq_reg < msq) ? (msq - sq_reg) : (sq_reg - msq);
  assign fld_re = to_field(res, bneg);
  assign fld_im = to_field(res, rneg);

  // operand selection for the unit
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (cmd.step)
      STEP_IP_MUL: begin op_a = UW'(adi);            op_b = UW'(adx); end
      STEP_IP_DIV: begin op_a = res;                  op_b = UW'(dm); end
      STEP_RATIO:  begin op_a = UW'({apsi, 16'd0});   op_b = UW'(apsi0); end
      STEP_A:      begin op_a = UW'(res_mass);        op_b = UW'(res_width); end
      STEP_M0SQ:   begin op_a = UW'(res_mass);        op_b = UW'(res_mass); end
      STEP_MSQ:    begin op_a = UW'(mass_reg);        op_b = UW'(mass_reg); end
      STEP_C:      begin op_a = UW'(a_reg);           op_b = UW'(r_reg); end
      STEP_BB:     begin op_a = UW'(bmag);            op_b = UW'(bmag); end
      STEP_CC:     begin op_a = UW'(cmag);            op_b = UW'(cmag); end
      STEP_NRE:    begin op_a = UW'(a_reg);           op_b = UW'(bmag); end
      STEP_DRE:    begin op_a = res;                  op_b = UW'(den_reg); end
      STEP_NIM:    begin op_a = UW'(a_reg);           op_b = UW'(cmag); end
      STEP_DIM:    begin op_a = res;                  op_b = UW'(den_reg); end
      default:     begin op_a = '0;                   op_b = '0; end
    endcase
  end

  bwtw_muldiv u_muldiv (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.op == OP_START),
    .is_div (step_is_div(cmd.step)),
    .op_a   (op_a),
    .op_b   (op_b),
    .done   (unit_done),
    .result (res)
  );

  // capture of input and unit results
  always_ff @(posedge clk) begin
    if (cmd.op == OP_CAPTURE) begin
      mass_reg <= mass;
      sat      <= 1'b0;
    end else if (cmd.op == OP_PSI_DIRECT) begin
      if (cmd.pass) psi_m0 <= PSI_W'(il);
      else          psi_m  <= PSI_W'(il);
    end else if (cmd.op == OP_LATCH) begin
      case (cmd.step)
        STEP_IP_DIV: begin
          if (cmd.pass) psi_m0 <= v_clip[PSI_W-1:0];
          else          psi_m  <= v_clip[PSI_W-1:0];
          if (q_over || v_sat) sat <= 1'b1;
        end
        STEP_RATIO: begin
          if (res > UW'(32'h7FFF_FFFF)) begin
            r_reg <= '1;
            sat   <= 1'b1;
          end else begin
            r_reg <= res[30:0];
          end
        end
        STEP_A:    a_reg  <= res[63:0];
        STEP_M0SQ: sq_reg <= res[63:0];
        STEP_MSQ: begin
          bneg <= sq_reg < msq;
          bmag <= bdiff[63:24];
        end
        STEP_C:  cmag    <= res[94:40];
        STEP_BB: bb_reg  <= res[79:0];
        STEP_CC: den_reg <= 111'(bb_reg) + res[110:0];
        STEP_DRE: begin
          re_reg <= fld_re.field;
          if (fld_re.sat) sat <= 1'b1;
        end
        STEP_DIM: begin
          im_reg <= fld_im.field;
          if (fld_im.sat) sat <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.op == OP_EMIT) begin
      amp_real  <= cmd.inv ? 32'sd0 : $signed(re_reg);
      amp_imag  <= cmd.inv ? 32'sd0 : $signed(im_reg);
      saturated <= cmd.inv ? 1'b0 : sat;
      invalid   <= cmd.inv;
    end
  end

  // status toward the controller
  assign status.scan_done = scan_done;
  assign status.seg_flat  = mc <= ml;
  assign status.unit_done = unit_done;
  assign status.ref_zero  = psi_m0 == '0;
  assign status.den_zero  = den_reg == '0;

endmodule

// ===== rtl/core/bwtw_ctrl.sv =====
// controller state machine sequencing scans and unit operations
`timescale 1ns / 1ps
module bwtw_ctrl import bwtw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    action,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output cmd_t    cmd,
  input  status_t status
);

  state_t state, state_next;
  step_t  step, step_next;
  logic   pass, pass_next;
  logic   inv, inv_next;
  logic   out_valid_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= STEP_IP_MUL;
      pass      <= 1'b0;
      inv       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      pass      <= pass_next;
      inv       <= inv_next;
      out_valid <= out_valid_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    pass_next      = pass;
    inv_next       = inv;
    out_valid_next = out_valid && out_stall;
    in_stall       = 1'b1;
    cmd.op         = OP_NONE;
    cmd.step       = step;
    cmd.pass       = pass;
    cmd.inv        = inv;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (action) begin
            cmd.op     = OP_CAPTURE;
            pass_next  = 1'b0;
            inv_next   = 1'b0;
            state_next = S_SCAN_INIT;
          end else begin
            cmd.op = OP_LOAD;
          end
        end
      end
      S_SCAN_INIT: begin
        cmd.op     = OP_SCAN_INIT;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.op = OP_SCAN;
        if (status.scan_done) state_next = S_SEG;
      end
      S_SEG: begin
        if (status.seg_flat) begin
          cmd.op     = OP_PSI_DIRECT;
          state_next = S_PASS;
        end else begin
          step_next  = STEP_IP_MUL;
          state_next = S_GO;
        end
      end
      S_PASS: begin
        if (!pass) begin
          pass_next  = 1'b1;
          state_next = S_SCAN_INIT;
        end else begin
          state_next = S_CHK_REF;
        end
      end
      S_GO: begin
        cmd.op     = OP_START;
        state_next = S_WAIT;
      end
      S_WAIT: begin
        if (status.unit_done) begin
          cmd.op     = OP_LATCH;
          state_next = S_GO;
          case (step)
            STEP_IP_MUL: step_next = STEP_IP_DIV;
            STEP_IP_DIV: state_next = S_PASS;
            STEP_RATIO:  step_next = STEP_A;
            STEP_A:      step_next = STEP_M0SQ;
            STEP_M0SQ:   step_next = STEP_MSQ;
            STEP_MSQ:    step_next = STEP_C;
            STEP_C:      step_next = STEP_BB;
            STEP_BB:     step_next = STEP_CC;
            STEP_CC:     state_next = S_CHK_DEN;
            STEP_NRE:    step_next = STEP_DRE;
            STEP_DRE:    step_next = STEP_NIM;
            STEP_NIM:    step_next = STEP_DIM;
            STEP_DIM:    state_next = S_FIN;
            default:     state_next = S_IDLE;
          endcase
        end
      end
      S_CHK_REF: begin
        if (status.ref_zero) begin
          inv_next   = 1'b1;
          state_next = S_FIN;
        end else begin
          step_next  = STEP_RATIO;
          state_next = S_GO;
        end
      end
      S_CHK_DEN: begin
        if (status.den_zero) begin
          inv_next   = 1'b1;
          state_next = S_FIN;
        end else begin
          step_next  = STEP_NRE;
          state_next = S_GO;
        end
      end
      S_FIN: begin
        if (!out_valid || !out_stall) begin
          cmd.op         = OP_EMIT;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/breit_wigner_tabulated_width.sv =====
// Breit-Wigner amplitude with tabulated width: a load transaction is taken without leaving idle.
// An evaluate transaction holds the block for up to two table scans of one table entry
// per cycle, then up to ten multiplies and five divides on one shared multiply/divide
// unit that retires one bit per cycle.
// The result register frees the block for the next transaction while a result waits.
// Synchronous reset clears control and sets M0 = 0, G0 = 0, point count 2; table undefined.
`timescale 1ns / 1ps
module breit_wigner_tabulated_width import bwtw_pkg::*; #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               action,
  input  logic [5:0]         point_index,
  input  logic [31:0]        point_mass,
  input  logic [31:0]        point_integral,
  input  logic [31:0]        mass,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] amp_real,
  output logic signed [31:0] amp_imag,
  output logic               saturated,
  output logic               invalid
);

  cmd_t    cmd;
  status_t status;

  // sequencing
  bwtw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  // storage and arithmetic
  bwtw_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .point_index    (point_index),
    .point_mass     (point_mass),
    .point_integral (point_integral),
    .mass           (mass),
    .amp_real       (amp_real),
    .amp_imag       (amp_imag),
    .saturated      (saturated),
    .invalid        (invalid)
  );

`ifndef ASSERT_OFF
  // an invalid result carries zero fields
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && invalid) |-> (amp_real == 32'sd0 && amp_imag == 32'sd0 && !saturated))
    else $error("invalid result with nonzero fields");

  // an evaluate transaction occupies the block
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && action) |=> in_stall)
    else $error("input taken while evaluation in progress");

  // no result appears right after an input transaction
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !$rose(out_valid))
    else $error("result raised without evaluation");
`endif

endmodule

// ===== dv/tb_top.sv =====
// self-checking testbench for the tabulated-width breit-wigner block
`timescale 1ns / 1ps
module tb_top;
  import bwtw_pkg::*;

  localparam int DEPTH  = 64;
  localparam int SETTLE = 1500;

  typedef struct packed {
    logic [31:0] re;
    logic [31:0] im;
    logic        sat;
    logic        inv;
  } amp_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_LOAD, ROW_EVAL} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  reg_idx;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    bit          typed;
    amp_t        want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_write = 1'b0;
  logic [1:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               action = 1'b0;
  logic [5:0]         point_index = '0;
  logic [31:0]        point_mass = '0;
  logic [31:0]        point_integral = '0;
  logic [31:0]        mass = '0;
  logic               out_valid;
  logic               out_stall = 1'b1;
  logic signed [31:0] amp_real;
  logic signed [31:0] amp_imag;
  logic               saturated;
  logic               invalid;

  // shadow copy of block state
  logic [31:0] tab_mass [DEPTH];
  logic [31:0] tab_integral [DEPTH];
  logic [31:0] m0_q;
  logic [31:0] g0_q;
  logic [6:0]  count_q;

  amp_t        pending_amps [$];
  int          errors = 0;
  int          sent = 0;
  int          next_gap = 0;
  int          out_hold = 3;
  bit          quiet = 1'b0;

  breit_wigner_tabulated_width dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #50_000_000;
    $display("tb_top: errors");
    $finish;
  end

  function automatic int draw_wait();
    return quiet ? 0 : $urandom_range(0, 16);
  endfunction

  // linear interpolation of the integral table at x
  function automatic longint interp_integral(logic [31:0] x, inout bit sat);
    longint      lim;
    int          n;
    int          seg;
    logic [31:0] ml, mc, il, ic;
    logic [63:0] adi, adx, q;
    longint      v;
    lim = longint'(1) << 40;
    n   = (count_q < 2) ? 2 : ((count_q > DEPTH) ? DEPTH : int'(count_q));
    seg = n - 2;
    for (int i = 1; i < n; i++) begin
      if (tab_mass[i-1] <= x && x < tab_mass[i]) begin
        seg = i - 1;
        break;
      end
    end
    ml = tab_mass[seg];
    mc = tab_mass[seg+1];
    il = tab_integral[seg];
    ic = tab_integral[seg+1];
    if (mc <= ml) return longint'({32'b0, il});
    adi = (ic < il) ? 64'(il - ic) : 64'(ic - il);
    adx = (x < ml) ? 64'(ml - x) : 64'(x - ml);
    q = (adi * adx) / 64'(mc - ml);
    if (q > (64'd1 << 41)) begin
      q   = 64'd1 << 41;
      sat = 1'b1;
    end
    if ((ic < il) != (x < ml)) v = longint'({32'b0, il}) - longint'(q);
    else v = longint'({32'b0, il}) + longint'(q);
    if (v > lim) begin
      v   = lim;
      sat = 1'b1;
    end
    if (v < -lim) begin
      v   = -lim;
      sat = 1'b1;
    end
    return v;
  endfunction

  function automatic logic [31:0] clip_field(logic [127:0] q, bit sign, inout bit sat);
    bit          neg;
    logic [31:0] limit;
    logic [31:0] mag;
    neg   = sign && (q != '0);
    limit = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag   = q[31:0];
    if (q[127:32] != '0 || q[31:0] > limit) begin
      mag = limit;
      sat = 1'b1;
    end
    return neg ? (~mag + 32'd1) : mag;
  endfunction

  // amplitude at mass m with the current table and registers
  function automatic amp_t breit_wigner(logic [31:0] m);
    amp_t         r;
    bit           sat, bneg, rneg;
    longint       psi, psi0;
    logic [63:0]  apsi, apsi0, ratio, a, m0sq, msq, bmag, cmag;
    logic [127:0] c, d, re, im;
    sat  = 1'b0;
    r    = '{re: '0, im: '0, sat: 1'b0, inv: 1'b1};
    psi  = interp_integral(m, sat);
    psi0 = interp_integral(m0_q, sat);
    if (psi0 == 0) return r;
    apsi  = (psi < 0) ? 64'(-psi) : 64'(psi);
    apsi0 = (psi0 < 0) ? 64'(-psi0) : 64'(psi0);
    rneg  = (psi < 0) != (psi0 < 0);
    ratio = (apsi << 16) / apsi0;
    if (ratio > 64'h7FFF_FFFF) begin
      ratio = 64'h7FFF_FFFF;
      sat   = 1'b1;
    end
    a    = 64'(m0_q) * 64'(g0_q);
    m0sq = 64'(m0_q) * 64'(m0_q);
    msq  = 64'(m) * 64'(m);
    bneg = m0sq < msq;
    bmag = (bneg ? msq - m0sq : m0sq - msq) >> 24;
    c    = 128'(a) * 128'(ratio);
    cmag = c[103:40];
    d    = 128'(bmag) * 128'(bmag) + 128'(cmag) * 128'(cmag);
    if (d == '0) return r;
    re = (128'(a) * 128'(bmag)) / d;
    im = (128'(a) * 128'(cmag)) / d;
    r.re  = clip_field(re, bneg, sat);
    r.im  = clip_field(im, rneg, sat);
    r.sat = sat;
    r.inv = 1'b0;
    return r;
  endfunction

  // register write while the block is idle
  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_RES_MASS:    m0_q = data;
      REG_RES_WIDTH:   g0_q = data;
      REG_POINT_COUNT: count_q = data[6:0];
      default: ;
    endcase
  endtask

  // wait until all results are in and the block has settled
  task automatic drain();
    cfg_write <= 1'b0;
    if (next_gap == 0) in_valid <= 1'b0;
    next_gap = 1;
    wait (pending_amps.size() == 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // one input transaction; typed results override the predictor
  task automatic send(logic act, logic [5:0] idx, logic [31:0] pm, logic [31:0] pi,
                      logic [31:0] m, bit typed, amp_t want);
    cfg_write <= 1'b0;
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    in_valid       <= 1'b1;
    action         <= act;
    point_index    <= idx;
    point_mass     <= pm;
    point_integral <= pi;
    mass           <= m;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    if (act == 1'b0) begin
      tab_mass[idx]     = pm;
      tab_integral[idx] = pi;
    end else begin
      pending_amps.insert(pending_amps.size(), typed ? want : breit_wigner(m));
    end
    sent++;
    next_gap = draw_wait();
    if (next_gap > 0) in_valid <= 1'b0;
  endtask

  task automatic load(logic [5:0] idx, logic [31:0] pm, logic [31:0] pi);
    send(1'b0, idx, pm, pi, $urandom, 1'b0, '0);
  endtask

  task automatic evaluate(logic [31:0] m);
    send(1'b1, 6'($urandom), $urandom, $urandom, m, 1'b0, '0);
  endtask

  // result side stall, drawn per transaction, counted while a result waits
  always @(posedge clk) begin
    int h;
    if (rst) begin
      out_stall <= 1'b1;
      out_hold  <= 3;
    end else begin
      h = out_hold;
      if (out_valid && !out_stall) h = draw_wait();
      else if (out_valid && h != 0) h = h - 1;
      out_hold  <= h;
      out_stall <= (h != 0);
    end
  end

  // result check, sampled mid-cycle ahead of the accepting edge
  always @(negedge clk) begin
    amp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_amps.size() == 0) begin
        $display("%0t: result with none expected: real %h imag %h", $realtime,
                 amp_real, amp_imag);
        errors++;
      end else begin
        want = pending_amps.pop_front();
        if (amp_real !== want.re) begin
          $display("%0t: amp_real expected %h actual %h", $realtime, want.re, amp_real);
          errors++;
        end
        if (amp_imag !== want.im) begin
          $display("%0t: amp_imag expected %h actual %h", $realtime, want.im, amp_imag);
          errors++;
        end
        if (saturated !== want.sat) begin
          $display("%0t: saturated expected %b actual %b", $realtime, want.sat, saturated);
          errors++;
        end
        if (invalid !== want.inv) begin
          $display("%0t: invalid expected %b actual %b", $realtime, want.inv, invalid);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t        rows [$];
    amp_t        inv_amp;
    logic [31:0] base, step, m;
    int          n_items;
    inv_amp = '{re: '0, im: '0, sat: 1'b0, inv: 1'b1};
    m0_q    = '0;
    g0_q    = '0;
    count_q = 7'd2;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // fill every slot so no unwritten entry is ever read
    for (int i = 0; i < DEPTH; i++)
      load(6'(i), 32'(i) << 26, (i == 0) ? 32'd0 : 32'(i + 1) << 16);

    // directed rows: reset state, extremes, clipping, flat segment, odd counts
    rows = '{
      '{ROW_EVAL, 2'd0, 32'd0,          0, 0, 1'b1, inv_amp},
      '{ROW_CFG,  REG_RES_MASS,    32'h1000_0000, 0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_RES_WIDTH,   32'h0100_0000, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'd0,          0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'hFFFF_FFFF,  0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h1000_0000,  0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_POINT_COUNT, 32'd64, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'hFFFF_FFFF,  0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h0A12_3456,  0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_POINT_COUNT, 32'd127, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h0FFF_0000,  0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_POINT_COUNT, 32'd0, 0, 0, 1'b0, '0},
      '{ROW_CFG,  2'd3,            32'hFFFF_FFFF, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h0200_0000,  0, 0, 1'b0, '0},
      '{ROW_LOAD, 2'd0, 32'd1, 32'd0, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h0300_0000,  0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_RES_MASS,    32'hFFFF_FFFF, 0, 0, 1'b0, '0},
      '{ROW_CFG,  REG_RES_WIDTH,   32'hFFFF_FFFF, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'd0,          0, 0, 1'b0, '0},
      '{ROW_LOAD, 2'd0, 32'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0},
      '{ROW_LOAD, 2'd0, 32'd1, 32'h0400_0000, 32'h0002_0000, 1'b0, '0},
      '{ROW_CFG,  REG_RES_WIDTH,   32'd0, 0, 0, 1'b0, '0},
      '{ROW_EVAL, 2'd0, 32'h0400_0000,  0, 0, 1'b0, '0}
    };
    foreach (rows[i]) begin
      case (rows[i].kind)
        ROW_CFG: begin
          drain();
          write_reg(rows[i].reg_idx, rows[i].a);
        end
        ROW_LOAD: load(rows[i].a[5:0], rows[i].b, rows[i].c);
        default:  send(1'b1, '0, '0, '0, rows[i].a, rows[i].typed, rows[i].want);
      endcase
    end

    // random phases: new registers, often a fresh ascending table, then traffic
    while (sent < 550) begin
      drain();
      quiet = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 4))
        0:       write_reg(REG_POINT_COUNT, $urandom_range(0, 1));
        1:       write_reg(REG_POINT_COUNT, $urandom_range(64, 127));
        default: write_reg(REG_POINT_COUNT, $urandom_range(2, 16));
      endcase
      write_reg(REG_RES_WIDTH, ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> 4);
      if ($urandom_range(0, 7) == 0) write_reg(2'd3, $urandom);
      if ($urandom_range(0, 2) != 0) begin
        base = $urandom >> 2;
        step = $urandom_range(1, 32'h0200_0000);
        write_reg(REG_RES_MASS, base + $urandom_range(0, 15) * step
                  + $urandom_range(0, step));
        for (int i = 0; i < 16; i++)
          load(6'(i), base + 32'(i) * step,
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom >> 8);
      end else begin
        write_reg(REG_RES_MASS, $urandom);
      end
      n_items = $urandom_range(8, 20);
      for (int k = 0; k < n_items; k++) begin
        case ($urandom_range(0, 9))
          0, 1:    load(6'($urandom), $urandom, $urandom);
          2, 3:    evaluate($urandom);
          4:       evaluate(tab_mass[$urandom_range(0, 15)]);
          default: begin
            m = m0_q + $urandom_range(0, 32'h0040_0000) - 32'h0020_0000;
            evaluate(m);
          end
        endcase
      end
    end

    if (next_gap == 0) in_valid <= 1'b0;
    cfg_write <= 1'b0;
    wait (pending_amps.size() == 0);
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
